[design/rqdel_pkg.sv]
// ----------------------------------------------------------------------------
// rqdel_pkg
// Shared constants, codes and types for the ring queue with delete by value.
// ----------------------------------------------------------------------------
`default_nettype none

package rqdel_pkg;

    localparam int DEPTH      = 4;
    localparam int DATA_WIDTH = 16;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;

    // Operation codes
    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIND   = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    typedef logic [DATA_WIDTH-1:0] t_data;
    typedef logic [CNT_W-1:0]      t_count;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;  // latch operation and compare all cells
        logic execute;  // apply update and register the result
    } t_ctrl_cmd;

endpackage

`default_nettype wire

[design/rqdel_ctrl.sv]
// ----------------------------------------------------------------------------
// rqdel_ctrl
// Two-state sequencer: takes a transaction, then runs the update step.
// ----------------------------------------------------------------------------
`default_nettype none

module rqdel_ctrl
    import rqdel_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    output t_ctrl_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_cmd.capture = (r_state == S_IDLE) && start;
    assign o_cmd.execute = (r_state == S_EXEC);

endmodule

`default_nettype wire

[design/rqdel_dpath.sv]
// ----------------------------------------------------------------------------
// rqdel_dpath
// Row of queue cells kept in order from the head, match compare, compaction.
// ----------------------------------------------------------------------------
`default_nettype none

module rqdel_dpath
    import rqdel_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_ctrl_cmd           i_cmd,
    input  wire logic [KIND_W-1:0]   i_kind,
    input  wire t_data               i_value_in,
    output logic                     o_strobe,
    output logic [STATUS_W-1:0]      o_status,
    output t_data                    o_value_out,
    output t_count                   o_count
);

    // cell 0 is always the head; the queue stays packed toward it
    t_data              r_cells [DEPTH];
    t_count             r_occ;
    logic [KIND_W-1:0]  r_kind;
    t_data              r_value;
    logic [DEPTH-1:0]   r_match;

    logic               r_strobe;
    logic [STATUS_W-1:0] r_status;
    t_data              r_value_out;
    t_count             r_count;

    logic [DEPTH-1:0]   n_match;
    logic [DEPTH-1:0]   shift_vec;
    logic               found;
    logic               full;
    logic               empty;

    // compare every occupied cell against the incoming value
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_match[i] = (r_cells[i] == i_value_in) && (t_count'(i) < r_occ);
        end
    end

    // cells at and above the first match move one place toward the head
    always_comb begin
        logic acc;
        acc = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
            acc          = acc | r_match[i];
            shift_vec[i] = acc;
        end
        found = acc;
    end

    assign full  = (r_occ == t_count'(DEPTH));
    assign empty = (r_occ == '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind  <= i_kind;
            r_value <= i_value_in;
            r_match <= n_match;
        end
    end

    // last cell is never a shift target; it only empties out
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            case (r_kind)
                KIND_APPEND: begin
                    for (int i = 0; i < DEPTH; i++) begin
                        if (!full && (r_occ == t_count'(i))) r_cells[i] <= r_value;
                    end
                end
                KIND_REMOVE: begin
                    for (int i = 0; i < DEPTH - 1; i++) begin
                        if (!empty) r_cells[i] <= r_cells[i + 1];
                    end
                end
                KIND_FIND: begin
                    for (int i = 0; i < DEPTH - 1; i++) begin
                        if (shift_vec[i]) r_cells[i] <= r_cells[i + 1];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.execute;
            if (i_cmd.execute) begin
                case (r_kind)
                    KIND_APPEND: if (!full)  r_occ <= r_occ + t_count'(1);
                    KIND_REMOVE: if (!empty) r_occ <= r_occ - t_count'(1);
                    KIND_FIND:   if (found)  r_occ <= r_occ - t_count'(1);
                    default: begin
                    end
                endcase
            end
        end
    end

    // result registers; count reflects the state after the operation
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_status    <= ST_OK;
            r_value_out <= '0;
            r_count     <= r_occ;
            case (r_kind)
                KIND_APPEND: begin
                    if (full) begin
                        r_status <= ST_FULL;
                    end else begin
                        r_count  <= r_occ + t_count'(1);
                    end
                end
                KIND_REMOVE: begin
                    if (empty) begin
                        r_status <= ST_EMPTY;
                    end else begin
                        r_value_out <= r_cells[0];
                        r_count     <= r_occ - t_count'(1);
                    end
                end
                KIND_FIND: begin
                    if (found) begin
                        r_count  <= r_occ - t_count'(1);
                    end else begin
                        r_status <= ST_NOTFOUND;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_strobe    = r_strobe;
    assign o_status    = r_status;
    assign o_value_out = r_value_out;
    assign o_count     = r_count;

endmodule

`default_nettype wire

[design/ring_queue_with_delete_by_value.sv]
// ----------------------------------------------------------------------------
// ring_queue_with_delete_by_value
// Fixed-depth FIFO queue with append, remove head and find-and-remove.
// ----------------------------------------------------------------------------
//
// Channel   Signals                          Direction  Handshake
// -------   -------------------------------  ---------  ---------------------
// command   start, i_kind, i_value_in        in         start & !busy
// result    o_strobe, o_status,              out        o_strobe, one cycle,
//           o_value_out, o_count                        no back-pressure
//
// Each transaction is accepted, then updated: the accept edge compares every
// occupied cell against i_value_in in parallel and registers the matches,
// and the S_EXEC state applies the update (append, shift toward head, or
// compaction past the first match). busy is high for the single update
// cycle; the result strobes in the cycle after it, alongside the next accept
// if start is held. Reset (i_rst_n low, synchronous) empties the queue; cell
// contents are not cleared and never read while unoccupied.
// The receiver cannot stall: every result is shown for exactly one cycle.
//
// Cells are kept packed from the head (cell 0), so head and tail pointers
// reduce to the occupancy count. Operation kind three is a no-op that
// reports ok with the current count.
// ----------------------------------------------------------------------------
`default_nettype none

module ring_queue_with_delete_by_value
    import rqdel_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [KIND_W-1:0]   i_kind,
    input  wire t_data               i_value_in,
    output logic                     o_strobe,
    output logic [STATUS_W-1:0]      o_status,
    output t_data                    o_value_out,
    output t_count                   o_count
);

    t_ctrl_cmd cmd;

    rqdel_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    rqdel_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_kind      (i_kind),
        .i_value_in  (i_value_in),
        .o_strobe    (o_strobe),
        .o_status    (o_status),
        .o_value_out (o_value_out),
        .o_count     (o_count)
    );

endmodule

`default_nettype wire
